>>> rtl/core/tste_pkg.sv
// Shared types, constants and helpers for the typed segment text extractor.
package tste_pkg;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_TYPE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_TEXT = 4'b1000
  } phase_e;

  // One result transaction as it leaves the parser
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       block_end;
  } result_t;

  localparam int unsigned NumTextKinds = 9;
  localparam logic [7:0] NewlineByte = 8'h0A;
  localparam logic [7:0] UpperFirst  = 8'h41;  // 'A'
  localparam logic [7:0] UpperLast   = 8'h5A;  // 'Z'
  localparam logic [1:0] LenLastIdx  = 2'd3;

  // Type bytes whose text is kept: m l g t x y k w h
  localparam logic [7:0] TextKinds [NumTextKinds] = '{
    8'h6D, 8'h6C, 8'h67, 8'h74, 8'h78, 8'h79, 8'h6B, 8'h77, 8'h68
  };

  function automatic logic is_text_kind(logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int unsigned k = 0; k < NumTextKinds; k++) begin
      if (TextKinds[k] == b) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> rtl/core/tste_parse.sv
// Segment parser: mode register, parse state and per-byte result logic.
module tste_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              acc_i,
  input  logic [7:0]        in_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output tste_pkg::result_t res_o
);

  logic                 pass_q;
  tste_pkg::phase_e     phase_q, phase_d;
  logic [23:0]          len_q, len_d;
  logic [1:0]           len_cnt_q, len_cnt_d;
  logic [31:0]          skip_q, skip_d;
  logic                 seg_text_q, seg_text_d;
  logic                 any_out_q, any_out_d;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic [31:0]          full_len;

  assign full_len = {len_q, in_byte_i};

  // Next parse state and output byte for the byte on the input
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    len_cnt_d  = len_cnt_q;
    skip_d     = skip_q;
    seg_text_d = seg_text_q;
    emit       = 1'b0;
    emit_byte  = in_byte_i;
    if (pass_q) begin
      emit = 1'b1;
    end else begin
      unique case (phase_q)
        tste_pkg::PH_TYPE: begin
          if (in_byte_i >= tste_pkg::UpperFirst && in_byte_i <= tste_pkg::UpperLast) begin
            phase_d   = tste_pkg::PH_LEN;
            len_d     = '0;
            len_cnt_d = '0;
          end else begin
            seg_text_d = tste_pkg::is_text_kind(in_byte_i);
            phase_d    = tste_pkg::PH_TEXT;
            if (seg_text_d && any_out_q) begin
              emit      = 1'b1;
              emit_byte = tste_pkg::NewlineByte;
            end
          end
        end
        tste_pkg::PH_LEN: begin
          len_d = full_len[23:0];
          if (len_cnt_q == tste_pkg::LenLastIdx) begin
            len_cnt_d = '0;
            skip_d    = full_len;
            phase_d   = (full_len == '0) ? tste_pkg::PH_TYPE : tste_pkg::PH_SKIP;
          end else begin
            len_cnt_d = len_cnt_q + 2'd1;
          end
        end
        tste_pkg::PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = tste_pkg::PH_TYPE;
          end
        end
        tste_pkg::PH_TEXT: begin
          if (in_byte_i == 8'h00) begin
            phase_d    = tste_pkg::PH_TYPE;
            seg_text_d = 1'b0;
          end else if (seg_text_q) begin
            emit = 1'b1;
          end
        end
        default: begin
          phase_d = tste_pkg::PH_TYPE;
        end
      endcase
    end
    any_out_d = any_out_q | emit;
    // final byte returns the parse to its reset state
    if (last_byte_i) begin
      phase_d    = tste_pkg::PH_TYPE;
      len_d      = '0;
      len_cnt_d  = '0;
      skip_d     = '0;
      seg_text_d = 1'b0;
      any_out_d  = 1'b0;
    end
  end

  // Result transaction: any emitted byte, and always the final byte
  assign push_o          = acc_i & (emit | last_byte_i);
  assign res_o.out_byte  = emit ? emit_byte : 8'h00;
  assign res_o.out_valid = emit;
  assign res_o.block_end = last_byte_i;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 1'b0;
    end else if (cfg_we_i) begin
      pass_q <= cfg_data_i;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tste_pkg::PH_TYPE;
      len_q      <= '0;
      len_cnt_q  <= '0;
      skip_q     <= '0;
      seg_text_q <= 1'b0;
      any_out_q  <= 1'b0;
    end else if (acc_i) begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      len_cnt_q  <= len_cnt_d;
      skip_q     <= skip_d;
      seg_text_q <= seg_text_d;
      any_out_q  <= any_out_d;
    end
  end

  // The skip phase always has bytes left to skip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tste_pkg::PH_SKIP) |-> (skip_q != 32'd0))
    else $error("skip phase with zero bytes remaining");

  // A final byte leaves the parser in its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && last_byte_i) |=> (phase_q == tste_pkg::PH_TYPE && !any_out_q && !seg_text_q))
    else $error("parse state not cleared after block end");

endmodule

>>> rtl/core/tste_out_buf.sv
// Result register with a skid stage so input and output sides decouple.
module tste_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tste_pkg::result_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output tste_pkg::result_t res_o
);

  tste_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic              pop;

  assign pop     = out_v_q & ready_i;
  assign ready_o = ~skid_v_q;
  assign valid_o = out_v_q;
  assign res_o   = out_q;

  // Move skid into the output slot on pop, park a new result in skid on stall
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_d   = res_i;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      if (!out_v_q) begin
        out_d   = res_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Skid only holds data behind a full output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full while output slot empty");

  // A stalled output with a full skid draws no new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !ready_i) |=> (skid_v_q && $stable(skid_q)))
    else $error("skid stage changed during stall");

endmodule

>>> rtl/core/typed_segment_text_extractor.sv
// Top level of the typed segment text extractor.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one byte of a definition
//   block per transaction, with last_byte_i set on its final byte.
//   Result channel (res_valid_o/res_ready_i) carries out_byte_o, out_valid_o
//   and block_end_o. A result is made for every kept text byte (every byte
//   when pass_through is set), for each newline separator, and always for the final byte of a block.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes pass_through;
//   write it only while no block is in flight.
// Output: each result is registered in the output slot, or parked in the skid
//   stage while that slot is full. Throughput: one byte per cycle while
//   in_ready_o is high; the parser state update is a single compare/decrement
//   step, and a result register plus skid stage absorb one stalled result.
// Stall: when the receiver holds res_ready_i low, one more result is parked
//   in the skid stage, then in_ready_o drops until the receiver takes one.
// Reset: pass_through clears to 0, the parser returns to expecting a type
//   byte, and both result slots empty.
module typed_segment_text_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_pass_through_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       block_end_o
);

  logic              acc;
  logic              push;
  tste_pkg::result_t res_new, res_out;

  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i & in_ready_o;

  tste_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_pass_through_i),
    .acc_i       (acc),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .res_o       (res_new)
  );

  tste_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_new),
    .ready_o (in_ready_o),
    .valid_o (res_valid_o),
    .ready_i (res_ready_i),
    .res_o   (res_out)
  );

  assign out_byte_o  = res_out.out_byte;
  assign out_valid_o = res_out.out_valid;
  assign block_end_o = res_out.block_end;

endmodule
